// File: rtl/sbbn_pkg.sv
package sbbn_pkg;

    localparam int COORD_W = 12;
    localparam int GRID_W  = 9;
    localparam int NORM_W  = 8;

    // m = 2*(c-cmin)+S-span never exceeds 2*S, which fits 13 bits
    localparam int M_W    = COORD_W + 1;
    localparam int NUM_W  = NORM_W + M_W;
    localparam int STEP_W = 5;

    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(NORM_W - 1);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(NUM_W - 1);

    localparam logic [GRID_W-1:0] GRID_MIN = 9'd2;
    localparam logic [GRID_W-1:0] GRID_MAX = 9'd256;
    localparam logic [GRID_W-1:0] GRID_RST = 9'd100;

    localparam logic REG_TARGET_WIDTH  = 1'b0;
    localparam logic REG_TARGET_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_FETCH,
        ST_MUL,
        ST_DIV,
        ST_PUSH
    } state_t;

endpackage

// File: rtl/stroke_bounding_box_normalizer_core.sv
// stroke bounding box normaliser
// input channel (s_*): one pen point per item, s_stroke_end marks the last point of a
// stroke. points are taken one per cycle while loading; the box is tracked as they arrive.
// a point beyond MAX_POINTS is dropped and the whole stroke is flagged m_overflowed.
// result channel (m_*): after the marked point every stored point comes out rescaled into
// the target grid, in arrival order, m_run_last on the final one.
// config port: cfg_wr_en with cfg_index 0 (target_width) or 1 (target_height).
// emission: each result passes a memory read, an operand step, a bit-serial multiply by
// (grid-1) and a restoring division, one bit per cycle, then the push into the output
// register. the next point is computed while a result waits in the output register;
// s_ready stays low during emission.
// if the receiver stalls, the output register holds its item and the engine waits once
// the following result is ready.
// reset (aresetn, synchronous) empties the store, clears the box and drop flag, sets both
// grid sizes to 100 and drops any stroke in progress. the point store itself is not
// cleared: only entries written in the current stroke are read back.
module stroke_bounding_box_normalizer_core
    import sbbn_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_wr_en,
    input  logic                    cfg_index,
    input  logic [GRID_W-1:0]       cfg_wdata,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [COORD_W-1:0]      s_point_x,
    input  logic [COORD_W-1:0]      s_point_y,
    input  logic                    s_stroke_end,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [NORM_W-1:0]       m_norm_x,
    output logic [NORM_W-1:0]       m_norm_y,
    output logic                    m_run_last,
    output logic                    m_overflowed
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    // configuration
    logic [GRID_W-1:0] tw_reg, th_reg;
    logic [NORM_W-1:0] gm1_x, gm1_y;

    // load side
    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg;
    logic              drop_reg;
    logic [COORD_W-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic              accept, full;

    // point store, x in the upper half
    logic [2*COORD_W-1:0] store_mem [MAX_POINTS];
    logic [2*COORD_W-1:0] rd_data_reg;

    // emission control
    logic [CW-1:0]     idx_reg, n_reg;
    logic              drop_emit_reg;
    logic              is_last, out_free;
    logic [STEP_W-1:0] step_reg;

    // per-stroke scale terms
    logic [COORD_W-1:0] span_x_reg, span_y_reg, big_reg;
    logic [M_W-1:0]     den_reg;
    logic               big_zero_reg;
    logic [COORD_W-1:0] span_x, span_y;

    // serial arithmetic
    logic [M_W-1:0]    m_x_reg, m_y_reg;
    logic [NORM_W-1:0] gsh_x_reg, gsh_y_reg;
    logic [NUM_W-1:0]  acc_x_reg, acc_y_reg;
    logic [M_W-1:0]    rem_x_reg, rem_y_reg;
    logic [NORM_W-1:0] q_x_reg, q_y_reg;
    logic [M_W:0]      trial_x, trial_y;
    logic              ge_x, ge_y;

    // output register
    logic              m_valid_reg;
    logic [NORM_W-1:0] m_norm_x_reg, m_norm_y_reg;
    logic              m_run_last_reg, m_overflowed_reg;

    // grid sizes are clamped to 2..256, then reduced by one
    assign gm1_x = (tw_reg < GRID_MIN) ? NORM_W'(GRID_MIN - 9'd1) :
                   (tw_reg > GRID_MAX) ? NORM_W'(GRID_MAX - 9'd1) : NORM_W'(tw_reg - 9'd1);
    assign gm1_y = (th_reg < GRID_MIN) ? NORM_W'(GRID_MIN - 9'd1) :
                   (th_reg > GRID_MAX) ? NORM_W'(GRID_MAX - 9'd1) : NORM_W'(th_reg - 9'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tw_reg <= GRID_RST;
            th_reg <= GRID_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TARGET_WIDTH:  tw_reg <= cfg_wdata;
                REG_TARGET_HEIGHT: th_reg <= cfg_wdata;
                default:           tw_reg <= tw_reg;
            endcase
        end
    end

    assign s_ready  = (state_reg == ST_LOAD);
    assign accept   = s_valid && s_ready;
    assign full     = (count_reg == CW'(MAX_POINTS));
    assign is_last  = ((idx_reg + CW'(1)) == n_reg);
    assign out_free = !m_valid_reg || m_ready;

    assign span_x = max_x_reg - min_x_reg;
    assign span_y = max_y_reg - min_y_reg;

    // one restoring division step per cycle, numerator bits enter msb first
    assign trial_x = {rem_x_reg, acc_x_reg[NUM_W-1]};
    assign trial_y = {rem_y_reg, acc_y_reg[NUM_W-1]};
    assign ge_x    = (trial_x >= {1'b0, den_reg});
    assign ge_y    = (trial_y >= {1'b0, den_reg});

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (accept && s_stroke_end) state_next = ST_READ;
            end
            ST_READ:  state_next = ST_FETCH;
            ST_FETCH: state_next = ST_MUL;
            ST_MUL: begin
                if (step_reg == MUL_LAST) state_next = ST_DIV;
            end
            ST_DIV: begin
                if (step_reg == DIV_LAST) state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (out_free) state_next = is_last ? ST_LOAD : ST_READ;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // point store: one write port on load, one registered read port on emission
    always_ff @(posedge aclk) begin
        if (accept && !full) begin
            store_mem[count_reg[AW-1:0]] <= {s_point_x, s_point_y};
        end
        rd_data_reg <= store_mem[idx_reg[AW-1:0]];
    end

    // load bookkeeping and bounding box
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            min_x_reg     <= '0;
            max_x_reg     <= '0;
            min_y_reg     <= '0;
            max_y_reg     <= '0;
            idx_reg       <= '0;
            n_reg         <= '0;
            drop_emit_reg <= 1'b0;
        end else begin
            if (accept) begin
                if (!full) begin
                    if (count_reg == '0) begin
                        min_x_reg <= s_point_x;
                        max_x_reg <= s_point_x;
                        min_y_reg <= s_point_y;
                        max_y_reg <= s_point_y;
                    end else begin
                        if (s_point_x < min_x_reg) min_x_reg <= s_point_x;
                        if (s_point_x > max_x_reg) max_x_reg <= s_point_x;
                        if (s_point_y < min_y_reg) min_y_reg <= s_point_y;
                        if (s_point_y > max_y_reg) max_y_reg <= s_point_y;
                    end
                end
                // marked point: freeze the stroke for emission and restart loading
                if (s_stroke_end) begin
                    n_reg         <= full ? count_reg : count_reg + CW'(1);
                    drop_emit_reg <= drop_reg || full;
                    idx_reg       <= '0;
                    count_reg     <= '0;
                    drop_reg      <= 1'b0;
                end else if (full) begin
                    drop_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + CW'(1);
                end
            end else if (state_reg == ST_PUSH && out_free) begin
                idx_reg <= idx_reg + CW'(1);
            end
        end
    end

    // serial datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_READ: begin
                    // larger span scales both axes
                    span_x_reg   <= span_x;
                    span_y_reg   <= span_y;
                    big_reg      <= (span_x > span_y) ? span_x : span_y;
                    den_reg      <= {((span_x > span_y) ? span_x : span_y), 1'b0};
                    big_zero_reg <= (span_x == '0) && (span_y == '0);
                end
                ST_FETCH: begin
                    m_x_reg   <= M_W'({rd_data_reg[2*COORD_W-1:COORD_W] - min_x_reg, 1'b0})
                                 + M_W'(big_reg - span_x_reg);
                    m_y_reg   <= M_W'({rd_data_reg[COORD_W-1:0] - min_y_reg, 1'b0})
                                 + M_W'(big_reg - span_y_reg);
                    gsh_x_reg <= gm1_x;
                    gsh_y_reg <= gm1_y;
                    acc_x_reg <= '0;
                    acc_y_reg <= '0;
                    rem_x_reg <= '0;
                    rem_y_reg <= '0;
                    q_x_reg   <= '0;
                    q_y_reg   <= '0;
                    step_reg  <= '0;
                end
                ST_MUL: begin
                    // shift-and-add, grid bits msb first
                    acc_x_reg <= {acc_x_reg[NUM_W-2:0], 1'b0}
                                 + (gsh_x_reg[NORM_W-1] ? NUM_W'(m_x_reg) : '0);
                    acc_y_reg <= {acc_y_reg[NUM_W-2:0], 1'b0}
                                 + (gsh_y_reg[NORM_W-1] ? NUM_W'(m_y_reg) : '0);
                    gsh_x_reg <= {gsh_x_reg[NORM_W-2:0], 1'b0};
                    gsh_y_reg <= {gsh_y_reg[NORM_W-2:0], 1'b0};
                    step_reg  <= (step_reg == MUL_LAST) ? '0 : step_reg + STEP_W'(1);
                end
                ST_DIV: begin
                    // quotient is below the grid size, so the low 8 bits are enough
                    rem_x_reg <= ge_x ? M_W'(trial_x - {1'b0, den_reg}) : M_W'(trial_x);
                    rem_y_reg <= ge_y ? M_W'(trial_y - {1'b0, den_reg}) : M_W'(trial_y);
                    acc_x_reg <= {acc_x_reg[NUM_W-2:0], 1'b0};
                    acc_y_reg <= {acc_y_reg[NUM_W-2:0], 1'b0};
                    q_x_reg   <= {q_x_reg[NORM_W-2:0], ge_x};
                    q_y_reg   <= {q_y_reg[NORM_W-2:0], ge_y};
                    step_reg  <= step_reg + STEP_W'(1);
                end
                default: step_reg <= step_reg;
            endcase
        end
    end

    // output register, refilled while the engine works on the next point
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_PUSH && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_PUSH && out_free) begin
            // degenerate box: every point sits in the grid centre
            m_norm_x_reg     <= big_zero_reg ? (gm1_x >> 1) : q_x_reg;
            m_norm_y_reg     <= big_zero_reg ? (gm1_y >> 1) : q_y_reg;
            m_run_last_reg   <= is_last;
            m_overflowed_reg <= drop_emit_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_norm_x     = m_norm_x_reg;
    assign m_norm_y     = m_norm_y_reg;
    assign m_run_last   = m_run_last_reg;
    assign m_overflowed = m_overflowed_reg;

endmodule

// File: tb/stroke_bounding_box_normalizer_core_tb.sv
module stroke_bounding_box_normalizer_core_tb;
    import sbbn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 64;
    // settle time, longer than one result takes inside the engine
    localparam int SETTLE_CYCLES = 64;
    // long receiver hold-off, longer than a whole stroke's emission
    localparam int LONG_HOLD = 3000;
    localparam int PHASE_BUDGET = 14;

    typedef enum int {
        SH_SPREAD,
        SH_CLUSTER,
        SH_VLINE,
        SH_HLINE,
        SH_DOT
    } stroke_shape_t;

    typedef enum int {
        RX_FREE,
        RX_MOSTLY,
        RX_SPARSE,
        RX_TOGGLE
    } rx_mode_t;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
        bit                 wait_drain;
    } pen_item_t;

    typedef struct {
        logic [NORM_W-1:0] nx;
        logic [NORM_W-1:0] ny;
        logic              run_last;
        logic              overflowed;
    } norm_point_t;

    // clock, reset and block ports
    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic                cfg_index = REG_TARGET_WIDTH;
    logic [GRID_W-1:0]   cfg_wdata = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [COORD_W-1:0]  s_point_x = '0;
    logic [COORD_W-1:0]  s_point_y = '0;
    logic                s_stroke_end = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [NORM_W-1:0]   m_norm_x;
    logic [NORM_W-1:0]   m_norm_y;
    logic                m_run_last;
    logic                m_overflowed;

    // pen points waiting to be offered, and normalised points still owed by the block
    pen_item_t   pen_point_queue[$];
    norm_point_t pending_norm_points[$];

    // predictor's own copy of the block state
    logic [COORD_W-1:0]  pred_store_x[STORE_DEPTH];
    logic [COORD_W-1:0]  pred_store_y[STORE_DEPTH];
    logic [6:0]          pred_count = '0;
    logic [COORD_W-1:0]  pred_min_x = '0;
    logic [COORD_W-1:0]  pred_max_x = '0;
    logic [COORD_W-1:0]  pred_min_y = '0;
    logic [COORD_W-1:0]  pred_max_y = '0;
    logic                pred_dropped = 1'b0;
    logic [GRID_W-1:0]   pred_grid_w = GRID_RST;
    logic [GRID_W-1:0]   pred_grid_h = GRID_RST;

    int  errors = 0;
    // sender pacing
    bit  in_taken = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    // receiver pacing
    rx_mode_t rx_mode = RX_FREE;
    int  mode_left = 0;
    int  hold_left = 0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;

    stroke_bounding_box_normalizer_core #(
        .MAX_POINTS(STORE_DEPTH)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_point_x   (s_point_x),
        .s_point_y   (s_point_y),
        .s_stroke_end(s_stroke_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_norm_x    (m_norm_x),
        .m_norm_y    (m_norm_y),
        .m_run_last  (m_run_last),
        .m_overflowed(m_overflowed)
    );

    always #2 aclk = ~aclk;

    // grid register clamped into 2..256
    function automatic int unsigned grid_limit(input logic [GRID_W-1:0] r);
        if (r < GRID_MIN) return 32'(GRID_MIN);
        if (r > GRID_MAX) return 32'(GRID_MAX);
        return 32'(r);
    endfunction

    // exact integer form of the centred, aspect-keeping rescale of one coordinate
    function automatic logic [NORM_W-1:0] scale_coord(input logic [COORD_W-1:0] c,
                                                      input logic [COORD_W-1:0] cmin,
                                                      input logic [COORD_W-1:0] span,
                                                      input logic [COORD_W-1:0] big,
                                                      input int unsigned g);
        int unsigned num;
        // degenerate box: everything lands in the middle cell
        if (big == '0) return NORM_W'((g - 1) / 2);
        num = (g - 1) * (2 * (32'(c) - 32'(cmin)) + 32'(big) - 32'(span));
        return NORM_W'(num / (2 * 32'(big)));
    endfunction

    // store one accepted pen point and, on the stroke's last point, owe every stored point
    task automatic take_pen_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                  input logic last);
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] big;
        int unsigned gw;
        int unsigned gh;
        norm_point_t np;
        if (pred_count >= 7'(STORE_DEPTH)) begin
            // store full: point is lost, box untouched
            pred_dropped = 1'b1;
        end else begin
            if (pred_count == '0) begin
                pred_min_x = x;
                pred_max_x = x;
                pred_min_y = y;
                pred_max_y = y;
            end else begin
                if (x < pred_min_x) pred_min_x = x;
                if (x > pred_max_x) pred_max_x = x;
                if (y < pred_min_y) pred_min_y = y;
                if (y > pred_max_y) pred_max_y = y;
            end
            pred_store_x[pred_count] = x;
            pred_store_y[pred_count] = y;
            pred_count++;
        end
        if (last) begin
            gw  = grid_limit(pred_grid_w);
            gh  = grid_limit(pred_grid_h);
            sx  = pred_max_x - pred_min_x;
            sy  = pred_max_y - pred_min_y;
            big = (sx > sy) ? sx : sy;
            for (int i = 0; i < int'(pred_count); i++) begin
                np.nx = scale_coord(pred_store_x[i], pred_min_x, sx, big, gw);
                np.ny = scale_coord(pred_store_y[i], pred_min_y, sy, big, gh);
                np.run_last = (i + 1 == int'(pred_count));
                np.overflowed = pred_dropped;
                pending_norm_points.push_back(np);
            end
            pred_count = '0;
            pred_dropped = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // monitor: sample at the rising edge, config writes, results and accepted items
    always @(posedge aclk) begin
        norm_point_t want;
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_TARGET_WIDTH) pred_grid_w = cfg_wdata;
                else pred_grid_h = cfg_wdata;
            end
            if (m_valid && m_ready) begin
                if (pending_norm_points.size() == 0) begin
                    $error("unexpected result: norm_x %0d norm_y %0d", m_norm_x, m_norm_y);
                    errors++;
                end else begin
                    want = pending_norm_points.pop_front();
                    check_field("norm_x", want.nx, m_norm_x);
                    check_field("norm_y", want.ny, m_norm_y);
                    check_field("run_last", want.run_last, m_run_last);
                    check_field("overflowed", want.overflowed, m_overflowed);
                end
            end
            if (s_valid && s_ready) take_pen_point(s_point_x, s_point_y, s_stroke_end);
        end
    end

    // driver: bursts of items with random gaps, changes on the falling edge
    always @(negedge aclk) begin
        logic nv;
        pen_item_t it;
        nv = s_valid;
        if (!aresetn) begin
            nv = 1'b0;
        end else begin
            // the item on the port went in at the last rising edge
            if (s_valid && in_taken) nv = 1'b0;
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pen_point_queue.size() > 0 &&
                             !(pen_point_queue[0].wait_drain &&
                               pending_norm_points.size() != 0)) begin
                    it = pen_point_queue.pop_front();
                    s_point_x <= it.x;
                    s_point_y <= it.y;
                    s_stroke_end <= it.last;
                    nv = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else if ($urandom_range(0, 5) == 0) begin
                        // a stretch with no idling at all
                        burst_left = $urandom_range(30, 90);
                        gap_left = 0;
                    end else begin
                        burst_left = $urandom_range(0, 20);
                        gap_left = $urandom_range(0, 8);
                    end
                end
            end
        end
        s_valid <= nv;
    end

    // receiver: stall pattern of its own, plus one long hold-off during an emission
    always @(negedge aclk) begin
        logic r;
        if (mode_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        if (!aresetn) begin
            r = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            r = 1'b0;
        end else if (hold_req && !hold_done && m_valid) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            r = 1'b0;
        end else begin
            case (rx_mode)
                RX_FREE:   r = 1'b1;
                RX_MOSTLY: r = ($urandom_range(0, 3) != 0);
                RX_SPARSE: r = ($urandom_range(0, 3) == 0);
                default:   r = ~m_ready;
            endcase
        end
        m_ready <= r;
    end

    task automatic push_pen_point(input int x, input int y, input bit last,
                                  input bit wait_drain);
        pen_item_t it;
        it.x = COORD_W'(x);
        it.y = COORD_W'(y);
        it.last = last;
        it.wait_drain = wait_drain;
        pen_point_queue.push_back(it);
    endtask

    // one stroke of n points with a given spatial shape
    task automatic queue_stroke(input int n, input stroke_shape_t shape, input bit hold_first);
        int bx;
        int by;
        int x;
        int y;
        bx = $urandom_range(0, 4095 - 15);
        by = $urandom_range(0, 4095 - 15);
        for (int i = 0; i < n; i++) begin
            case (shape)
                SH_SPREAD: begin
                    x = $urandom_range(0, 4095);
                    y = $urandom_range(0, 4095);
                end
                SH_CLUSTER: begin
                    x = bx + $urandom_range(0, 15);
                    y = by + $urandom_range(0, 15);
                end
                SH_VLINE: begin
                    x = bx;
                    y = $urandom_range(0, 4095);
                end
                SH_HLINE: begin
                    x = $urandom_range(0, 4095);
                    y = by;
                end
                default: begin
                    x = bx;
                    y = by;
                end
            endcase
            push_pen_point(x, y, i == n - 1, hold_first && i == 0);
        end
    endtask

    task automatic write_grid_reg(input logic idx, input logic [GRID_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // everything offered, taken and answered, then let the engine settle
    task automatic wait_for_idle();
        while (pen_point_queue.size() != 0 || s_valid || pending_norm_points.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // stimulus: directed strokes at reset grid sizes, then random phases per setting
    initial begin
        logic [GRID_W-1:0] grid_w_set[9];
        logic [GRID_W-1:0] grid_h_set[9];
        int used;
        int n;
        int k;
        grid_w_set = '{9'd2, 9'd256, 9'd0, 9'd511, 9'd2, 9'd256, 9'd100, 9'd0, 9'd37};
        grid_h_set = '{9'd2, 9'd256, 9'd1, 9'd300, 9'd256, 9'd2, 9'd100, 9'd0, 9'd100};
        // two slots take random values, one inside the legal range and one anywhere
        grid_w_set[6] = GRID_W'($urandom_range(2, 256));
        grid_h_set[6] = GRID_W'($urandom_range(2, 256));
        grid_w_set[7] = GRID_W'($urandom_range(0, 511));
        grid_h_set[7] = GRID_W'($urandom_range(0, 511));

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        @(posedge aclk);
        // single point: zero span, lands mid grid
        push_pen_point(0, 0, 1, 0);
        // corners of the full coordinate range
        push_pen_point(4095, 4095, 0, 0);
        push_pen_point(0, 0, 0, 0);
        push_pen_point(4095, 0, 0, 0);
        push_pen_point(0, 4095, 1, 0);
        // repeated point, zero span on both axes
        push_pen_point(2048, 1000, 0, 1);
        push_pen_point(2048, 1000, 0, 0);
        push_pen_point(2048, 1000, 1, 0);
        // wider than tall, centred vertically
        push_pen_point(10, 500, 0, 0);
        push_pen_point(3000, 600, 1, 0);
        // taller than wide, centred horizontally
        push_pen_point(700, 5, 0, 0);
        push_pen_point(710, 4090, 1, 0);
        // span of one
        push_pen_point(1, 1, 0, 0);
        push_pen_point(2, 2, 1, 0);
        push_pen_point(4095, 4095, 1, 0);
        wait_for_idle();

        for (int p = 0; p < 9; p++) begin
            write_grid_reg(REG_TARGET_WIDTH, grid_w_set[p]);
            write_grid_reg(REG_TARGET_HEIGHT, grid_h_set[p]);
            @(posedge aclk);
            used = 0;
            if (p == 0) begin
                // exactly full, then full with the marked point dropped
                queue_stroke(STORE_DEPTH, SH_SPREAD, 0);
                queue_stroke(STORE_DEPTH + 1, SH_CLUSTER, 0);
            end
            // receiver goes quiet mid emission while the sender keeps offering
            if (p == 2) hold_req = 1'b1;
            k = 0;
            while (used < PHASE_BUDGET) begin
                if ($urandom_range(0, 19) == 0) n = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 8);
                else n = $urandom_range(1, 12);
                // second stroke of each phase waits for the previous one to drain
                queue_stroke(n, stroke_shape_t'($urandom_range(0, 4)),
                             k == 1 || $urandom_range(0, 3) == 0);
                used += n;
                k++;
            end
            wait_for_idle();
        end

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // run limit, many times the slowest expected run
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
